[rtl/core/dq_pkg.sv]
// Shared types and constants for the double-ended queue core.
`default_nettype none

package dq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int CMD_BITS    = 2;
   localparam int FIELD_BITS  = 32;
   localparam int OCC_BITS    = 5;
   localparam int STATUS_BITS = 2;
   localparam int RSP_BITS    = 2 * FIELD_BITS + 1 + OCC_BITS + STATUS_BITS;
   localparam int RSP_BYTES   = (RSP_BITS + 7) / 8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH_RIGHT = 2'd0,
      CMD_POP_LEFT   = 2'd1,
      CMD_POP_RIGHT  = 2'd2,
      CMD_PEEK       = 2'd3
   } dq_cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } dq_status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request and read both ends
      logic execute;   // update pointers, write slot, load response
   } dq_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/dq_ctrl.sv]
// Sequencer for the double-ended queue: request, execute, response.
`default_nettype none

module dq_ctrl
   import dq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output dq_ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      req_accept;

   // a new request may enter while the current response is being taken
   assign req_tready   = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_tready);
   assign req_accept   = req_tvalid && req_tready;
   assign rsp_tvalid   = (state_ff == ST_RESP);
   assign ctrl.load    = req_accept;
   assign ctrl.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = req_tvalid ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

[rtl/core/dq_datapath.sv]
// Slot memory, ring pointers and response register of the double-ended queue.
`default_nettype none

module dq_datapath
   import dq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dq_ctrl_type           ctrl,
   input  wire logic [CMD_BITS-1:0]   req_cmd,
   input  wire logic [FIELD_BITS-1:0] req_word,
   output logic [RSP_BITS-1:0]        rsp_data
);

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] slots_ff [DEPTH];

   logic [IDX_BITS-1:0]  left_ff, left_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   dq_cmd_type           cmd_ff;
   logic [WORD_BITS-1:0] value_ff;
   logic [WORD_BITS-1:0] rd_left_ff, rd_right_ff;
   logic [RSP_BITS-1:0]  rsp_ff;

   logic [IDX_BITS-1:0]  right_idx, push_idx;
   logic                 is_empty, is_full, do_push;
   logic [WORD_BITS-1:0] left_word, right_word;
   dq_status_type        status;

   // left + offset modulo DEPTH; both operands are below DEPTH
   function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] base,
                                                    input logic [IDX_BITS-1:0] off);
      logic [IDX_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_BITS+1)'(DEPTH)) sum = sum - (IDX_BITS+1)'(DEPTH);
      return sum[IDX_BITS-1:0];
   endfunction

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_BITS'(DEPTH));
   assign right_idx = is_empty ? left_ff : ring_add(left_ff, IDX_BITS'(count_ff - 1'b1));
   assign push_idx  = is_full ? left_ff : ring_add(left_ff, IDX_BITS'(count_ff));

   // capture the request and read both ends of the current ring
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff      <= dq_cmd_type'(req_cmd);
         value_ff    <= WORD_BITS'(req_word);
         rd_left_ff  <= slots_ff[left_ff];
         rd_right_ff <= slots_ff[right_idx];
      end
   end

   always_comb begin
      left_in    = left_ff;
      count_in   = count_ff;
      left_word  = '0;
      right_word = '0;
      status     = STATUS_OK;
      do_push    = 1'b0;
      unique case (cmd_ff)
         CMD_PUSH_RIGHT: begin
            if (is_full) begin
               status = STATUS_OVERFLOW;
            end else begin
               do_push  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_LEFT: begin
            if (is_empty) begin
               status = STATUS_UNDERFLOW;
            end else begin
               left_word = rd_left_ff;
               left_in   = ring_add(left_ff, IDX_BITS'(1));
               count_in  = count_ff - 1'b1;
            end
         end
         CMD_POP_RIGHT: begin
            if (is_empty) begin
               status = STATUS_UNDERFLOW;
            end else begin
               right_word = rd_right_ff;
               count_in   = count_ff - 1'b1;
            end
         end
         CMD_PEEK: begin
            if (is_empty) begin
               status = STATUS_UNDERFLOW;
            end else begin
               left_word  = rd_left_ff;
               right_word = rd_right_ff;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
      // an emptied ring restarts at slot zero
      if (count_in == '0) left_in = '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute && do_push) slots_ff[push_idx] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.execute) begin
         left_ff  <= left_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         rsp_ff <= {status, OCC_BITS'(count_in), (count_in == '0),
                    FIELD_BITS'(right_word), FIELD_BITS'(left_word)};
      end
   end

   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("item count beyond depth");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff < IDX_BITS'(DEPTH) || DEPTH == (1 << IDX_BITS))
      else $error("left index outside ring");

   a_empty_left: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> left_ff == '0)
      else $error("empty ring with nonzero left index");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      ctrl.execute && status != STATUS_OK |=>
         count_ff == $past(count_ff) && left_ff == $past(left_ff))
      else $error("rejected request changed state");

endmodule

`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
// Top level of the double-ended queue core: controller and datapath.
// An accepted request has both ring ends read into registers; the pointer update,
// slot write and response load follow, and the response is held valid until taken.
// No new request is taken while a request executes.
// A new request is taken in the same cycle the pending response is taken.
// Reset clears the left index and item count; slot contents stay unset.
`default_nettype none

module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [FIELD_BITS-1:0]  req_tdata,  // push_value
   input  wire logic [CMD_BITS-1:0]    req_tuser,  // cmd
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // left_word, right_word, is_empty, occupancy, status
   output logic [RSP_BYTES*8-1:0]      rsp_tdata
);

   dq_ctrl_type         ctrl;
   logic [RSP_BITS-1:0] rsp_data;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   dq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_cmd  (req_tuser),
      .req_word (req_tdata),
      .rsp_data (rsp_data)
   );

   assign rsp_tdata = (RSP_BYTES*8)'(rsp_data);

endmodule

`default_nettype wire

[test/dq_checker.sv]
// Response checker for the double-ended queue core: predicts every response and compares.
module dq_checker
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [FIELD_BITS-1:0]  req_tdata,   // push_value
   input  wire logic [CMD_BITS-1:0]    req_tuser,   // cmd
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // left_word, right_word, is_empty, occupancy, status
   input  wire logic [RSP_BYTES*8-1:0] rsp_tdata,
   output int                          mismatch_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;
   localparam int REPLY_SLOTS = 8;

   typedef struct packed {
      logic [FIELD_BITS-1:0] left_word;
      logic [FIELD_BITS-1:0] right_word;
      logic                  is_empty;
      logic [OCC_BITS-1:0]   occupancy;
      dq_status_type         status;
   } deque_reply_type;

   logic [FIELD_BITS-1:0] ring_slots [DEPTH];
   int unsigned           head_pos;
   int unsigned           held_items;
   deque_reply_type       awaited_replies [REPLY_SLOTS];
   int unsigned           reply_wr;
   int unsigned           reply_rd;
   deque_reply_type       want;
   logic [RSP_BYTES*8-1:0] want_bits;

   // Advances the deque image by one request and returns the response it must produce.
   function automatic deque_reply_type deque_apply(dq_cmd_type op,
                                                   logic [FIELD_BITS-1:0] word);
      deque_reply_type r;
      r = '0;
      r.status = STATUS_OK;
      if (op == CMD_PUSH_RIGHT) begin
         if (held_items >= DEPTH) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            ring_slots[(head_pos + held_items) % DEPTH] = word;
            held_items++;
         end
      end else if (held_items == 0) begin
         r.status = STATUS_UNDERFLOW;
      end else begin
         if (op == CMD_POP_LEFT) begin
            r.left_word = ring_slots[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
            held_items--;
         end else if (op == CMD_POP_RIGHT) begin
            r.right_word = ring_slots[(head_pos + held_items - 1) % DEPTH];
            held_items--;
         end else begin
            r.left_word  = ring_slots[head_pos];
            r.right_word = ring_slots[(head_pos + held_items - 1) % DEPTH];
         end
         // draining the queue re-homes the left end
         if (held_items == 0) head_pos = 0;
      end
      r.is_empty  = (held_items == 0);
      r.occupancy = held_items[OCC_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_pos = 0;
         held_items = 0;
         reply_wr = 0;
         reply_rd = 0;
         mismatch_count = 0;
         pending_count <= 0;
      end else begin
         // a response always belongs to an earlier request, so check it first
         if (rsp_tvalid && rsp_tready) begin
            if (reply_wr == reply_rd) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with no request pending: %h", $realtime, rsp_tdata);
            end else begin
               want = awaited_replies[reply_rd % REPLY_SLOTS];
               reply_rd++;
               want_bits = {want.status, want.occupancy, want.is_empty,
                            want.right_word, want.left_word};
               if (rsp_tdata !== want_bits) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: response mismatch: expected left %h right %h empty %b",
                              $realtime, want.left_word, want.right_word, want.is_empty,
                              " occ %0d status %0d, got left %h right %h empty %b",
                              want.occupancy, want.status, rsp_tdata[31:0], rsp_tdata[63:32],
                              rsp_tdata[64],
                              " occ %0d status %0d",
                              rsp_tdata[69:65], rsp_tdata[71:70]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_replies[reply_wr % REPLY_SLOTS] =
               deque_apply(dq_cmd_type'(req_tuser), req_tdata);
            reply_wr++;
         end
         pending_count <= int'(reply_wr - reply_rd);
      end
   end

endmodule

[test/tb_double_ended_queue_core.sv]
// Testbench top for the double-ended queue core: clock, reset, request stimulus and verdict.
module tb_double_ended_queue_core;
   timeunit 1ns;
   timeprecision 1ps;
   import dq_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_REQUESTS = 450;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic [FIELD_BITS-1:0]   req_tdata = '0;
   logic [CMD_BITS-1:0]     req_tuser = '0;
   logic                    rsp_tready = 1'b0;
   logic                    req_tready;
   logic                    rsp_tvalid;
   logic [RSP_BYTES*8-1:0]  rsp_tdata;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count;
   int pending_count;
   int cycle_count = 0;

   double_ended_queue_core #(
      .DEPTH     (DEPTH_DEFAULT),
      .WORD_BITS (WORD_BITS_DEFAULT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dq_checker #(
      .DEPTH (DEPTH_DEFAULT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[double_ended_queue_core] ERROR");
         $finish;
      end
   end

   // Presents one request after a random idle gap and holds it until taken.
   // tvalid is left high on return so back-to-back requests never toggle it.
   task automatic send_request(input dq_cmd_type op, input logic [FIELD_BITS-1:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      int                    remaining;
      int                    burst;
      int                    push_pct;
      dq_cmd_type            op;
      logic [FIELD_BITS-1:0] word;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // underflow on every non-push command while empty, then two pushes peeked and popped
      send_request(CMD_POP_LEFT, 32'hFFFF_FFFF);
      send_request(CMD_POP_RIGHT, 32'h0000_0000);
      send_request(CMD_PEEK, 32'h1234_5678);
      send_request(CMD_PUSH_RIGHT, 32'h0000_0000);
      send_request(CMD_PUSH_RIGHT, 32'hFFFF_FFFF);
      send_request(CMD_PEEK, 32'h0);
      send_request(CMD_POP_LEFT, 32'h0);
      send_request(CMD_POP_RIGHT, 32'h0);
      // fill to the brim, then overflow
      for (int i = 0; i < DEPTH_DEFAULT; i++) begin
         word = (i == 0) ? 32'hAAAA_AAAA : (i == 1) ? 32'h5555_5555 : $urandom;
         send_request(CMD_PUSH_RIGHT, word);
      end
      send_request(CMD_PUSH_RIGHT, 32'hDEAD_BEEF);
      // move the left end off zero so the next push wraps the ring
      send_request(CMD_POP_LEFT, 32'h0);
      send_request(CMD_PUSH_RIGHT, 32'hC001_D00D);
      send_request(CMD_PEEK, 32'h0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 76;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 76;
            end
            default: begin
               sender_idle_pct = 16;
               receiver_stall_pct = 16;
            end
         endcase
         remaining = PHASE_REQUESTS;
         while (remaining > 0) begin
            // bursts biased toward filling or draining sweep the whole occupancy range
            burst = $urandom_range(40, 10);
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
            for (int k = 0; k < burst && remaining > 0; k++) begin
               if ($urandom_range(99) < push_pct) op = CMD_PUSH_RIGHT;
               else op = dq_cmd_type'($urandom_range(3, 1));
               case ($urandom_range(15))
                  0: word = '0;
                  1: word = '1;
                  default: word = $urandom;
               endcase
               send_request(op, word);
               remaining--;
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[double_ended_queue_core] OK");
      end else begin
         $display("[double_ended_queue_core] ERROR");
      end
      $finish;
   end

endmodule

[double_ended_queue_core.f]
rtl/core/dq_pkg.sv
rtl/core/dq_ctrl.sv
rtl/core/dq_datapath.sv
rtl/core/double_ended_queue_core.sv
test/dq_checker.sv
test/tb_double_ended_queue_core.sv
